// File: design/jdj_pkg.sv
// ----------------------------------------------------------------------------
// jdj_pkg
// Types, widths and codes shared by the joystick deadzone jog integrator.
// ----------------------------------------------------------------------------
package jdj_pkg;

    localparam int NUM_AXES   = 8;
    localparam int NUM_JOINTS = 7;
    localparam int NUM_JOGS   = 6;
    localparam int AXIS_W     = 16;
    localparam int SRC_W      = AXIS_W + 1;
    localparam int DZ_W       = 15;
    localparam int STEP_W     = 8;
    localparam int POS_W      = 32;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = DZ_W;
    localparam int IN_DATA_W  = NUM_AXES * AXIS_W;
    localparam int OUT_DATA_W = NUM_JOINTS * POS_W;

    localparam logic [AXIS_W-1:0] Q_ONE        = 16'd16384;
    localparam logic [DZ_W-1:0]   DZ_RESET     = 15'd6554;
    localparam logic [STEP_W-1:0] STEP_RESET   = 8'd5;

    // Register indexes on the configuration port.
    localparam logic [CFG_ADDR_W-1:0] CFG_DEADZONE = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_STEP     = 1'b1;

    // Item kinds carried on s_tuser.
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    typedef logic signed [AXIS_W-1:0] axis_t;
    typedef logic signed [POS_W-1:0]  pos_t;

    // Triggers rest at 1.0 instead of 0.
    function automatic logic is_trigger_axis(input int idx);
        return (idx == 2) || (idx == 5);
    endfunction

    // Axis that drives each of joints 0 to 5.
    function automatic int jog_axis(input int joint);
        int res;
        case (joint)
            0: res = 0;
            1: res = 1;
            2: res = 3;
            3: res = 4;
            4: res = 6;
            5: res = 7;
            default: res = 0;
        endcase
        return res;
    endfunction

endpackage

// File: design/jdj_qual.sv
// ----------------------------------------------------------------------------
// jdj_qual
// Deadzone qualification of one axis; one copy per axis.
// ----------------------------------------------------------------------------
module jdj_qual import jdj_pkg::*; (
    input  axis_t             axis,
    input  logic              is_trig,
    input  logic [DZ_W-1:0]   deadzone,
    output axis_t             qualified,
    output logic              moved
);

    logic [AXIS_W+1:0] centered;
    logic [AXIS_W+1:0] negated;
    logic [AXIS_W:0]   mag;
    logic              in_zone;

    always_comb begin
        // Triggers are measured from their rest point at 1.0.
        centered = {{2{axis[AXIS_W-1]}}, axis}
                 - (is_trig ? {2'b00, Q_ONE} : {(AXIS_W+2){1'b0}});
        negated  = -centered;
        mag      = centered[AXIS_W+1] ? negated[AXIS_W:0] : centered[AXIS_W:0];
        in_zone  = mag < {2'b00, deadzone};
        moved    = !in_zone;
        if (!in_zone) begin
            qualified = axis;
        end else if (is_trig) begin
            qualified = axis_t'(Q_ONE);
        end else begin
            qualified = '0;
        end
    end

endmodule

// File: design/jdj_jog.sv
// ----------------------------------------------------------------------------
// jdj_jog
// One joint position: adds source times step, saturating to 32 bits.
// ----------------------------------------------------------------------------
module jdj_jog import jdj_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     jog_en,
    input  logic signed [SRC_W-1:0]  src,
    input  logic [STEP_W-1:0]        step,
    output pos_t                     pos_upd
);

    localparam int PROD_W = SRC_W + STEP_W + 1;
    localparam int SUM_W  = POS_W + 2;

    logic signed [PROD_W-1:0] prod;
    logic [SUM_W-1:0]         sum;
    pos_t                     pos_reg;
    pos_t                     pos_next;

    always_comb begin
        prod = src * $signed({1'b0, step});
        sum  = {{2{pos_reg[POS_W-1]}}, pos_reg}
             + {{(SUM_W-PROD_W){prod[PROD_W-1]}}, prod};
        // The top three bits disagree only when the sum left the 32-bit range.
        if (sum[SUM_W-1:POS_W-1] == '0 || sum[SUM_W-1:POS_W-1] == '1) begin
            pos_upd = pos_t'(sum[POS_W-1:0]);
        end else if (sum[SUM_W-1]) begin
            pos_upd = {1'b1, {(POS_W-1){1'b0}}};
        end else begin
            pos_upd = {1'b0, {(POS_W-1){1'b1}}};
        end
        pos_next = jog_en ? pos_upd : pos_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
    end

endmodule

// File: design/jdj_outq.sv
// ----------------------------------------------------------------------------
// jdj_outq
// Two-slot result buffer: output register plus skid slot.
// ----------------------------------------------------------------------------
module jdj_outq import jdj_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  logic [OUT_DATA_W-1:0]  push_data,
    output logic                   full,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata
);

    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic                  skid_valid_reg, skid_valid_next;
    logic [OUT_DATA_W-1:0] skid_data_reg, skid_data_next;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (out_valid_reg && m_tready) begin
            out_valid_next  = skid_valid_reg;
            out_data_next   = skid_data_reg;
            skid_valid_next = 1'b0;
        end
        if (push) begin
            if (!out_valid_next) begin
                out_valid_next = 1'b1;
                out_data_next  = push_data;
            end else begin
                skid_valid_next = 1'b1;
                skid_data_next  = push_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign full     = skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// File: design/joystick_deadzone_jog_integrator.sv
// ----------------------------------------------------------------------------
// joystick_deadzone_jog_integrator
// A tick that jogs writes its word into the output register, or into the skid slot when that register stays full.
// Throughput: one input word per cycle; eight axis lanes and seven jog lanes work
// in parallel, and s_tready drops only while both output slots hold words.
// Reset (synchronous, aresetn low) zeroes axes, flag and positions and restores
// the register defaults.
// ----------------------------------------------------------------------------
module joystick_deadzone_jog_integrator import jdj_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Configuration write port.
    input  logic                   cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    // Input words.
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_DATA_W-1:0]   s_tdata,   // axis_0 .. axis_7, 16 bits each
    input  logic                   s_tuser,   // command: 0 sample, 1 tick
    // Result words.
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata    // joint_1 .. joint_6, gripper, 32 bits each
);

    logic [DZ_W-1:0]   deadzone_reg, deadzone_next;
    logic [STEP_W-1:0] step_reg, step_next;
    axis_t             axes_reg [NUM_AXES];
    axis_t             axes_next [NUM_AXES];
    logic              moved_reg, moved_next;

    axis_t             lane_q [NUM_AXES];
    logic [NUM_AXES-1:0] lane_moved;
    logic signed [SRC_W-1:0] jog_src [NUM_JOINTS];
    pos_t              jog_upd [NUM_JOINTS];
    logic [OUT_DATA_W-1:0] result;

    logic accept, take_sample, emit, q_full;

    assign s_tready    = !q_full;
    assign accept      = s_tvalid && s_tready;
    assign take_sample = accept && (s_tuser == CMD_SAMPLE);
    assign emit        = accept && (s_tuser == CMD_TICK) && moved_reg;

    genvar gi;
    generate
        for (gi = 0; gi < NUM_AXES; gi++) begin : g_axis
            jdj_qual u_qual (
                .axis      (axis_t'(s_tdata[gi*AXIS_W +: AXIS_W])),
                .is_trig   (is_trigger_axis(gi)),
                .deadzone  (deadzone_reg),
                .qualified (lane_q[gi]),
                .moved     (lane_moved[gi])
            );
        end

        for (gi = 0; gi < NUM_JOGS; gi++) begin : g_src
            assign jog_src[gi] = {axes_reg[jog_axis(gi)][AXIS_W-1], axes_reg[jog_axis(gi)]};
        end
        // Gripper follows the difference of the two triggers.
        assign jog_src[NUM_JOGS] = {axes_reg[2][AXIS_W-1], axes_reg[2]}
                                 - {axes_reg[5][AXIS_W-1], axes_reg[5]};

        for (gi = 0; gi < NUM_JOINTS; gi++) begin : g_jog
            jdj_jog u_jog (
                .aclk    (aclk),
                .aresetn (aresetn),
                .jog_en  (emit),
                .src     (jog_src[gi]),
                .step    (step_reg),
                .pos_upd (jog_upd[gi])
            );
            assign result[gi*POS_W +: POS_W] = jog_upd[gi];
        end
    endgenerate

    always_comb begin
        deadzone_next = deadzone_reg;
        step_next     = step_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_DEADZONE: deadzone_next = cfg_wdata;
                CFG_STEP:     step_next     = cfg_wdata[STEP_W-1:0];
                default:      ;
            endcase
        end
        for (int i = 0; i < NUM_AXES; i++) begin
            axes_next[i] = take_sample ? lane_q[i] : axes_reg[i];
        end
        // Lanes merge here: any moved axis raises the flag for the next tick.
        moved_next = moved_reg;
        if (take_sample) begin
            moved_next = |lane_moved;
        end else if (emit) begin
            moved_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deadzone_reg <= DZ_RESET;
            step_reg     <= STEP_RESET;
            moved_reg    <= 1'b0;
            for (int i = 0; i < NUM_AXES; i++) begin
                axes_reg[i] <= '0;
            end
        end else begin
            deadzone_reg <= deadzone_next;
            step_reg     <= step_next;
            moved_reg    <= moved_next;
            for (int i = 0; i < NUM_AXES; i++) begin
                axes_reg[i] <= axes_next[i];
            end
        end
    end

    jdj_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (emit),
        .push_data (result),
        .full      (q_full),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// File: tb/sv/joystick_deadzone_jog_integrator_test.sv
// ----------------------------------------------------------------------------
// joystick_deadzone_jog_integrator_test
// Self-checking bench for the joystick deadzone jog integrator. Sample and tick
// words are fed on the input stream with random gaps while the result stream
// stalls at random. A behavioral predictor mirrors the deadzone qualification
// and the saturating joint integration. Every result word is compared, joint
// by joint, against the oldest predicted word. The run steps through several
// deadzone and step settings, the extremes among them, and drives the joint
// positions into both saturation limits.
// ----------------------------------------------------------------------------
module joystick_deadzone_jog_integrator_test;
    import jdj_pkg::*;

    localparam int     CYCLE_LIMIT = 300000;
    localparam longint POS_MAX     = (longint'(1) <<< (POS_W - 1)) - 1;
    localparam longint POS_MIN     = -(longint'(1) <<< (POS_W - 1));
    localparam logic [NUM_AXES-1:0] TRIGGER_MASK = 8'b0010_0100;

    typedef struct packed {
        logic                 cmd;
        logic [IN_DATA_W-1:0] axes;
    } jog_word_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    joystick_deadzone_jog_integrator i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Stimulus and scoreboard storage.
    jog_word_t             pending_words [$];
    logic [OUT_DATA_W-1:0] targets_due [$];
    int                    send_gap       = 0;
    int                    sink_stall     = 0;
    bit                    calm           = 1'b0;
    int                    mismatch_count = 0;
    int                    cycle_count    = 0;

    // Predictor state.
    int dz_now;
    int step_now;
    int held_axes [NUM_AXES];
    bit moved_seen;
    int joint_pos [NUM_JOINTS];

    int    jog_src [NUM_JOGS]     = '{0, 1, 3, 4, 6, 7};
    string joint_name [NUM_JOINTS] = '{"joint_1", "joint_2", "joint_3", "joint_4",
                                       "joint_5", "joint_6", "gripper"};

    task automatic report_mismatch(input string what);
        if (mismatch_count < 30)
            $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    function automatic int clamp32(input longint s);
        if (s > POS_MAX)
            return int'(POS_MAX);
        if (s < POS_MIN)
            return int'(POS_MIN);
        return int'(s);
    endfunction

    function automatic void jog_model_step(input logic cmd, input logic [IN_DATA_W-1:0] d);
        int                    a;
        int                    off;
        logic [OUT_DATA_W-1:0] word;
        if (cmd == CMD_SAMPLE) begin
            moved_seen = 1'b0;
            for (int i = 0; i < NUM_AXES; i++) begin
                a = int'(axis_t'(d[i*AXIS_W +: AXIS_W]));
                off = TRIGGER_MASK[i] ? a - int'(Q_ONE) : a;
                if (off < 0)
                    off = -off;
                if (off < dz_now) begin
                    held_axes[i] = TRIGGER_MASK[i] ? int'(Q_ONE) : 0;
                end else begin
                    held_axes[i] = a;
                    moved_seen = 1'b1;
                end
            end
        end else if (moved_seen) begin
            for (int j = 0; j < NUM_JOGS; j++)
                joint_pos[j] = clamp32(longint'(joint_pos[j])
                                       + longint'(held_axes[jog_src[j]]) * step_now);
            // The gripper follows the difference of the two triggers.
            joint_pos[NUM_JOINTS-1] = clamp32(longint'(joint_pos[NUM_JOINTS-1])
                + (longint'(held_axes[2]) - longint'(held_axes[5])) * step_now);
            for (int j = 0; j < NUM_JOINTS; j++)
                word[j*POS_W +: POS_W] = joint_pos[j];
            targets_due.push_back(word);
            moved_seen = 1'b0;
        end
    endfunction

    // Input side: one word per handshake, with random idle bursts.
    always @(posedge aclk) begin : feed
        jog_word_t next_word;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (send_gap != 0) begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end else if (pending_words.size() != 0) begin
                next_word = pending_words.pop_front();
                s_tvalid  <= 1'b1;
                s_tuser   <= next_word.cmd;
                s_tdata   <= next_word.axes;
                if (!calm && $urandom_range(0, 5) == 0)
                    send_gap <= $urandom_range(1, 14);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result side: random back-pressure bursts.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (sink_stall != 0) begin
            sink_stall <= sink_stall - 1;
            m_tready   <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            sink_stall <= $urandom_range(1, 14) - 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Checks results first: a result taken at this edge never stems from the
    // word accepted at the same edge.
    always @(posedge aclk) begin : watch
        logic [OUT_DATA_W-1:0] due;
        if (!aresetn) begin
            dz_now     = int'(DZ_RESET);
            step_now   = int'(STEP_RESET);
            moved_seen = 1'b0;
            for (int i = 0; i < NUM_AXES; i++)
                held_axes[i] = 0;
            for (int j = 0; j < NUM_JOINTS; j++)
                joint_pos[j] = 0;
        end else begin
            if (cfg_wr_en) begin
                if (cfg_addr == CFG_DEADZONE)
                    dz_now = int'(cfg_wdata);
                else if (cfg_addr == CFG_STEP)
                    step_now = int'(cfg_wdata[STEP_W-1:0]);
            end
            if (m_tvalid && m_tready) begin
                if (targets_due.size() == 0) begin
                    report_mismatch("result word with nothing expected");
                end else begin
                    due = targets_due.pop_front();
                    for (int j = 0; j < NUM_JOINTS; j++)
                        if (m_tdata[j*POS_W +: POS_W] !== due[j*POS_W +: POS_W])
                            report_mismatch($sformatf("%s got %0d, expected %0d",
                                joint_name[j], $signed(m_tdata[j*POS_W +: POS_W]),
                                $signed(due[j*POS_W +: POS_W])));
                end
            end
            if (s_tvalid && s_tready)
                jog_model_step(s_tuser, s_tdata);
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[joystick_deadzone_jog_integrator] ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Waits until every word is in and every result is out, then lets the
    // pipeline settle in case the last word was a tick with no result.
    task automatic wait_drained();
        do
            @(negedge aclk);
        while (pending_words.size() != 0 || s_tvalid || targets_due.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    function automatic logic [IN_DATA_W-1:0] set_axis(input logic [IN_DATA_W-1:0] d,
                                                      input int idx, input int val);
        d[idx*AXIS_W +: AXIS_W] = axis_t'(val);
        return d;
    endfunction

    function automatic logic [IN_DATA_W-1:0] rest_axes();
        logic [IN_DATA_W-1:0] d;
        for (int i = 0; i < NUM_AXES; i++)
            d[i*AXIS_W +: AXIS_W] = TRIGGER_MASK[i] ? Q_ONE : '0;
        return d;
    endfunction

    function automatic logic [IN_DATA_W-1:0] all_axes(input int val);
        logic [IN_DATA_W-1:0] d;
        for (int i = 0; i < NUM_AXES; i++)
            d[i*AXIS_W +: AXIS_W] = axis_t'(val);
        return d;
    endfunction

    // Mixes full-range values with values on and around the deadzone edges.
    function automatic int pick_axis(input bit trig, input int dz);
        int base;
        base = trig ? int'(Q_ONE) : 0;
        case ($urandom_range(0, 9))
            0, 1:    return int'($urandom_range(0, 65535)) - 32768;
            2, 3:    return int'($urandom_range(0, 32768)) - 16384;
            4:       return base + dz;
            5:       return base - dz;
            6:       return base + dz - 1;
            7:       return base - dz + 1;
            8:       return base;
            default: return base + int'($urandom_range(0, 2 * dz)) - dz;
        endcase
    endfunction

    function automatic logic [IN_DATA_W-1:0] random_axes(input int dz);
        logic [IN_DATA_W-1:0] d;
        for (int i = 0; i < NUM_AXES; i++)
            d[i*AXIS_W +: AXIS_W] = axis_t'(pick_axis(TRIGGER_MASK[i], dz));
        return d;
    endfunction

    // With a nonzero deadzone every axis lies strictly inside it, so the sample counts as at rest.
    function automatic logic [IN_DATA_W-1:0] quiet_axes(input int dz);
        logic [IN_DATA_W-1:0] d;
        d = rest_axes();
        if (dz > 0)
            for (int i = 0; i < NUM_AXES; i++)
                d = set_axis(d, i, (TRIGGER_MASK[i] ? int'(Q_ONE) : 0)
                                   + int'($urandom_range(0, 2 * dz - 2)) - (dz - 1));
        return d;
    endfunction

    task automatic queue_sample(input logic [IN_DATA_W-1:0] d);
        pending_words.push_back(jog_word_t'{cmd: CMD_SAMPLE, axes: d});
    endtask

    // Axis fields of a tick carry random junk.
    task automatic queue_tick();
        pending_words.push_back(jog_word_t'{cmd: CMD_TICK,
                                            axes: {$urandom, $urandom, $urandom, $urandom}});
    endtask

    task automatic queue_directed();
        int q;
        int dz;
        q  = int'(Q_ONE);
        dz = int'(DZ_RESET);
        queue_tick();
        queue_sample(rest_axes());
        queue_tick();
        queue_sample(set_axis(rest_axes(), 0, dz));
        queue_tick();
        queue_tick();
        queue_sample(set_axis(set_axis(rest_axes(), 0, dz - 1), 2, q - dz));
        queue_tick();
        queue_sample(set_axis(set_axis(rest_axes(), 5, q + dz - 1), 7, -(dz - 1)));
        queue_tick();
        queue_sample(all_axes(32767));
        queue_tick();
        queue_sample(all_axes(-32768));
        queue_tick();
        queue_sample(set_axis(set_axis(set_axis(all_axes(q), 1, -q), 2, -q), 5, q));
        queue_tick();
        // A sample at rest clears the flag left by the one before it.
        queue_sample(set_axis(rest_axes(), 3, -20000));
        queue_sample(rest_axes());
        queue_tick();
        queue_sample(set_axis(rest_axes(), 4, -dz));
        queue_tick();
        queue_sample(set_axis(set_axis(rest_axes(), 6, dz), 2, q + dz));
        queue_tick();
    endtask

    task automatic queue_random(input int count, input int dz);
        int k;
        int sel;
        k = 0;
        while (k < count) begin
            sel = $urandom_range(0, 9);
            if (sel < 7) begin
                queue_sample(random_axes(dz));
                queue_tick();
                k += 2;
            end else if (sel == 7) begin
                queue_tick();
                k += 1;
            end else if (sel == 8) begin
                queue_sample(quiet_axes(dz));
                queue_tick();
                k += 2;
            end else begin
                queue_sample(random_axes(dz));
                k += 1;
            end
        end
    endtask

    // Full deflection in one direction per joint: joints 1 to 3 run into the
    // upper limit, joints 4 to 6 and the gripper into the lower one.
    task automatic queue_drive(input int pairs);
        logic [IN_DATA_W-1:0] d;
        d = all_axes(32767);
        d = set_axis(set_axis(set_axis(d, 4, -32768), 6, -32768), 7, -32768);
        d = set_axis(d, 2, -32768);
        for (int p = 0; p < pairs; p++) begin
            queue_sample(d);
            queue_tick();
        end
    endtask

    initial begin
        int dz;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        queue_directed();
        wait_drained();

        // Zero deadzone and the largest step; junk above the step bits.
        write_reg(CFG_DEADZONE, '0);
        write_reg(CFG_STEP, {7'($urandom), 8'd255});
        queue_random(120, 0);
        wait_drained();
        queue_random(100, 0);
        wait_drained();

        write_reg(CFG_DEADZONE, 15'd16384);
        write_reg(CFG_STEP, '0);
        queue_random(100, 16384);
        wait_drained();

        dz = $urandom_range(0, 16000);
        write_reg(CFG_DEADZONE, 15'(dz));
        write_reg(CFG_STEP, 15'd255);
        queue_drive(300);
        wait_drained();

        dz = $urandom_range(0, 16384);
        write_reg(CFG_DEADZONE, 15'(dz));
        write_reg(CFG_STEP, 15'($urandom_range(1, 254)));
        queue_random(150, dz);
        wait_drained();
        calm = 1'b1;
        queue_random(100, dz);
        wait_drained();

        if (mismatch_count == 0)
            $display("[joystick_deadzone_jog_integrator] OK");
        else
            $display("[joystick_deadzone_jog_integrator] ERROR");
        $finish;
    end

endmodule
